// ===== rtl/range_add_range_sum_tree_macros.svh =====
// Assertion macros for the range sum tree checker
`ifndef RANGE_ADD_RANGE_SUM_TREE_MACROS_SVH
`define RANGE_ADD_RANGE_SUM_TREE_MACROS_SVH
`define RST_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/rast_pkg.sv =====
// ----------------------------------------------------------------------------
// rast_pkg
// Types and constants shared by the range sum tree modules.
// ----------------------------------------------------------------------------
`default_nettype none
package rast_pkg;
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_POP, ST_READ, ST_VISIT, ST_PUSH_L, ST_PUSH_R, ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_en;
    logic start;
    logic pop;
    logic read;
    logic visit;
    logic push_l;
    logic push_r;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic stack_empty;
    logic push;
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/rast_ctrl.sv =====
// ----------------------------------------------------------------------------
// rast_ctrl
// Controller: clear pass, then per item pop, read, visit until the stack empties.
// ----------------------------------------------------------------------------
`default_nettype none
module rast_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             go,
  input  wire             walk,
  input  wire rast_pkg::sts_t sts,
  output rast_pkg::cmd_t  cmd,
  output logic            busy
);
  import rast_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (go) begin
          cmd.start = 1'b1;
          state_nxt = walk ? ST_POP : ST_DONE;
        end
      end
      ST_POP: begin
        if (sts.stack_empty) state_nxt = ST_DONE;
        else begin
          cmd.pop = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read = 1'b1;
        state_nxt = ST_VISIT;
      end
      ST_VISIT: begin
        cmd.visit = 1'b1;
        state_nxt = sts.push ? ST_PUSH_L : ST_POP;
      end
      ST_PUSH_L: begin
        cmd.push_l = 1'b1;
        state_nxt = ST_PUSH_R;
      end
      ST_PUSH_R: begin
        cmd.push_r = 1'b1;
        state_nxt = ST_POP;
      end
      ST_DONE: begin
        cmd.done = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/rast_dp.sv =====
// ----------------------------------------------------------------------------
// rast_dp
// Datapath: node memories, walk stack, push-down of tags and accumulation.
// ----------------------------------------------------------------------------
`default_nettype none
module rast_dp #(
  parameter int MaxElements = 1024
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire rast_pkg::cmd_t cmd,
  input  wire              is_add,
  input  wire [10:0]       l_in,
  input  wire [10:0]       r_in,
  input  wire [63:0]       k_in,
  input  wire              err_in,
  output rast_pkg::sts_t   sts,
  output logic             out_valid,
  output logic [63:0]      out_sum,
  output logic             out_err
);
  import rast_pkg::*;
  localparam int NW = $clog2(MaxElements) + 2;
  localparam int PW = $clog2(MaxElements + 1) + 1;
  localparam int DEPTH = 1 << NW;
  localparam int SD = $clog2(MaxElements) + 2;
  localparam int SPW = $clog2(SD + 1);

  logic [63:0] sum_mem [DEPTH];
  logic [63:0] tag_mem [DEPTH];

  logic [NW-1:0] clr_r;
  logic [NW+2*PW-1:0] stk_r [SD];
  logic [SPW-1:0] sp_r;
  logic [PW-1:0] l_r, r_r;
  logic [63:0] k_r, tot_r;
  logic add_r, err_r;
  logic [NW-1:0] nd_r;
  logic [PW-1:0] lo_r, hi_r;
  logic [63:0] sum_rd_r, tag_rd_r;

  assign sts.clr_last = (clr_r == NW'(DEPTH - 1));
  assign sts.stack_empty = (sp_r == '0);

  logic [PW-1:0] mid, lo_c, hi_c;
  logic full, leaf;
  logic [NW-1:0] lc, rc;
  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign lo_c = (lo_r > l_r) ? lo_r : l_r;
  assign hi_c = (hi_r < r_r) ? hi_r : r_r;
  assign full = (lo_c == lo_r) && (hi_c == hi_r);
  assign leaf = (lo_r == hi_r);
  assign lc = {nd_r[NW-2:0], 1'b0};
  assign rc = {nd_r[NW-2:0], 1'b1};

  logic [63:0] cnt, cntl, cntr;
  assign cnt = 64'(hi_c - lo_c) + 64'd1;
  assign cntl = 64'(mid - lo_r) + 64'd1;
  assign cntr = 64'(hi_r - mid);

  logic [63:0] kc_r, tl_r, tr_r, tp_r;
  logic push;
  assign push = !full && !leaf && (tag_rd_r != 64'd0);
  assign sts.push = push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      sp_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.done;
      if (cmd.clr_en) clr_r <= clr_r + 1'b1;
      if (cmd.start) begin
        l_r <= PW'(l_in);
        r_r <= PW'(r_in);
        k_r <= k_in;
        add_r <= is_add;
        err_r <= err_in;
        tot_r <= '0;
        stk_r[0] <= {NW'(1), PW'(1), PW'(MaxElements)};
        sp_r <= SPW'(1);
      end
      if (cmd.pop) begin
        {nd_r, lo_r, hi_r} <= stk_r[sp_r - 1'b1];
        sp_r <= sp_r - 1'b1;
      end
      if (cmd.read) begin
        kc_r <= k_r * cnt;
        tl_r <= tag_rd_r * cntl;
        tr_r <= tag_rd_r * cntr;
      end
      if (cmd.visit) tp_r <= tag_rd_r;
      if (cmd.visit && lo_c <= hi_c) begin
        if (full) begin
          if (!add_r) tot_r <= tot_r + sum_rd_r;
        end else begin
          if (r_r > mid && l_r <= mid) begin
            stk_r[sp_r] <= {rc, mid + 1'b1, hi_r};
            stk_r[sp_r + 1'b1] <= {lc, lo_r, mid};
            sp_r <= sp_r + 2'd2;
          end else if (r_r > mid) begin
            stk_r[sp_r] <= {rc, mid + 1'b1, hi_r};
            sp_r <= sp_r + 1'b1;
          end else begin
            stk_r[sp_r] <= {lc, lo_r, mid};
            sp_r <= sp_r + 1'b1;
          end
        end
      end
      if (cmd.done) begin
        out_sum <= tot_r;
        out_err <= err_r;
      end
    end
  end

  logic [NW-1:0] ra;
  assign ra = cmd.pop    ? stk_r[sp_r - 1'b1][NW+2*PW-1:2*PW] :
              cmd.visit  ? lc :
              cmd.push_l ? rc : nd_r;

  always_ff @(posedge clk) begin
    sum_rd_r <= sum_mem[ra];
    tag_rd_r <= tag_mem[ra];
    if (cmd.clr_en) begin
      sum_mem[clr_r] <= '0;
      tag_mem[clr_r] <= '0;
    end else if (cmd.visit && lo_c <= hi_c) begin
      if (add_r) sum_mem[nd_r] <= sum_rd_r + kc_r;
      if (full) begin
        if (add_r) tag_mem[nd_r] <= tag_rd_r + k_r;
      end else if (push) begin
        tag_mem[nd_r] <= '0;
      end
    end else if (cmd.push_l) begin
      sum_mem[lc] <= sum_rd_r + tl_r;
      tag_mem[lc] <= tag_rd_r + tp_r;
    end else if (cmd.push_r) begin
      sum_mem[rc] <= sum_rd_r + tr_r;
      tag_mem[rc] <= tag_rd_r + tp_r;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/range_add_range_sum_tree.sv =====
// ----------------------------------------------------------------------------
// range_add_range_sum_tree
// Order: the result follows the walk over the visited nodes and any push-downs;
//   a rejected range or action 3 skips the walk and goes straight to the result.
// Busy drops as the result shows; a new item is taken only once the last is done.
// Reset: a clear pass zeroes all 4096 words (4*MaxElements) of the node memories.
// Results cannot be stalled; out_valid pulses one cycle per item.
// ----------------------------------------------------------------------------
`default_nettype none
module range_add_range_sum_tree #(
  parameter int MaxElements = 1024
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  in_action,
  input  wire  [10:0] in_range_left,
  input  wire  [10:0] in_range_right,
  input  wire  [63:0] in_value,
  output logic        out_valid,
  output logic [63:0] out_range_sum,
  output logic        out_range_error,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [10:0] cfg_array_size
);
  import rast_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic [10:0] size_r, eff, rr;
  logic bad, walk, go;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= 11'd1024;
    else if (cfg_valid) size_r <= cfg_array_size;
  end

  assign eff = (32'(size_r) > MaxElements) ? 11'(MaxElements) : size_r;
  assign rr = (in_action == ACT_LOAD) ? in_range_left : in_range_right;
  assign bad = (in_action != ACT_NONE) &&
               (in_range_left == 11'd0 || in_range_left > rr || rr > eff);
  assign walk = !bad && (in_action != ACT_NONE);
  assign go = start && !busy;

  rast_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .go(go), .walk(walk), .sts(sts), .cmd(cmd), .busy(busy)
  );

  rast_dp #(.MaxElements(MaxElements)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .is_add(in_action != ACT_QUERY), .l_in(in_range_left), .r_in(rr),
    .k_in(in_value), .err_in(bad), .sts(sts),
    .out_valid(out_valid), .out_sum(out_range_sum), .out_err(out_range_error)
  );
endmodule
`default_nettype wire

// ===== rtl/rast_chk.sv =====
// ----------------------------------------------------------------------------
// rast_chk
// Port-level checks on the range sum tree, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "range_add_range_sum_tree_macros.svh"
module rast_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire        out_valid,
  input wire [63:0] out_range_sum,
  input wire        out_range_error
);
  `RST_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `RST_ASSERT_NEXT(a_pulse, clk, rst_n, out_valid, !out_valid)
  `RST_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && out_range_error,
                   out_range_sum == 64'd0)
endmodule
bind range_add_range_sum_tree rast_chk u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_range_sum(out_range_sum), .out_range_error(out_range_error)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the lazy-tag range add / range sum tree against a flat array model.
// Directed loads, adds, queries and rejected ranges come first, then random
// traffic over several array sizes with bursty command timing.
// ----------------------------------------------------------------------------
module tb_top;
  import rast_pkg::*;

  localparam int unsigned TREE_SPAN = 1024;
  localparam int unsigned EXP_DEPTH = 16;

  typedef struct {
    logic [63:0] sum;
    logic        err;
  } sum_result_t;

  class range_sum_board;
    logic [63:0] elems [1:TREE_SPAN];
    int unsigned size_lim;
    sum_result_t exp_buf [EXP_DEPTH];
    int unsigned wr_cnt;
    int unsigned rd_cnt;
    int errors;

    function new();
      foreach (elems[i]) elems[i] = '0;
      size_lim = TREE_SPAN;
      wr_cnt = 0;
      rd_cnt = 0;
      errors = 0;
    endfunction

    function int unsigned outstanding();
      return wr_cnt - rd_cnt;
    endfunction

    function void set_size(logic [10:0] s);
      size_lim = (s > TREE_SPAN) ? TREE_SPAN : s;
    endfunction

    function void note_input(logic [1:0] act, logic [10:0] l, logic [10:0] r,
                             logic [63:0] v);
      sum_result_t res;
      logic [10:0] rr;
      res.sum = '0;
      res.err = 1'b0;
      rr = (act == ACT_LOAD) ? l : r;
      if (act != ACT_NONE) begin
        if (l == 0 || l > rr || rr > size_lim) begin
          res.err = 1'b1;
        end else if (act == ACT_QUERY) begin
          for (int i = l; i <= rr; i++) res.sum += elems[i];
        end else begin
          for (int i = l; i <= rr; i++) elems[i] += v;
        end
      end
      exp_buf[wr_cnt % EXP_DEPTH] = res;
      wr_cnt++;
    endfunction

    function void check_result(logic [63:0] sum, logic err);
      sum_result_t exp_res;
      if (outstanding() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result sum=%h err=%b", sum, err);
        return;
      end
      exp_res = exp_buf[rd_cnt % EXP_DEPTH];
      rd_cnt++;
      if (sum !== exp_res.sum || err !== exp_res.err) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected sum=%h err=%b, got sum=%h err=%b",
                   exp_res.sum, exp_res.err, sum, err);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = '0;
  logic [10:0] in_range_left = '0;
  logic [10:0] in_range_right = '0;
  logic [63:0] in_value = '0;
  logic        out_valid;
  logic [63:0] out_range_sum;
  logic        out_range_error;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_array_size = '0;

  range_sum_board board = new();
  int unsigned    cur_size = TREE_SPAN;

  always #2 clk = ~clk;

  range_add_range_sum_tree i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_range_left   (in_range_left),
    .in_range_right  (in_range_right),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_range_sum   (out_range_sum),
    .out_range_error (out_range_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_array_size  (cfg_array_size)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_range_sum, out_range_error);
  end

  task automatic send_item(logic [1:0] act, logic [10:0] l, logic [10:0] r,
                           logic [63:0] v);
    @(negedge clk);
    start = 1'b1;
    in_action = act;
    in_range_left = l;
    in_range_right = r;
    in_value = v;
    do @(posedge clk); while (busy);
    board.note_input(act, l, r, v);
  endtask

  task automatic idle_cycles(int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    idle_cycles(0);
    while (board.outstanding() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic write_size(logic [10:0] s);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_array_size = s;
    do @(posedge clk); while (!cfg_ready);
    board.set_size(s);
    cur_size = (s > TREE_SPAN) ? TREE_SPAN : s;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return 64'($signed($urandom_range(0, 200)) - 100);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_item();
    logic [10:0] l, r, t;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0 || cur_size == 0) begin
      send_item(2'($urandom), 11'($urandom), 11'($urandom), rand_value());
    end else begin
      l = 11'($urandom_range(1, cur_size));
      r = 11'($urandom_range(1, cur_size));
      if (l > r) begin
        t = l;
        l = r;
        r = t;
      end
      if (pick < 6) send_item(ACT_LOAD, l, 11'($urandom), rand_value());
      else if (pick < 12) send_item(ACT_ADD, l, r, rand_value());
      else if (pick < 19) send_item(ACT_QUERY, l, r, '0);
      else send_item(ACT_QUERY, l, 11'(cur_size + 1), '0);
    end
  endtask

  task automatic random_phase(int count);
    int n, burst;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        random_item();
        n++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed
    send_item(ACT_LOAD, 11'd1, 11'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(ACT_LOAD, 11'd1024, 11'd5, 64'h8000_0000_0000_0000);
    send_item(ACT_LOAD, 11'd512, 11'd512, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_QUERY, 11'd1, 11'd1024, '0);
    send_item(ACT_ADD, 11'd1, 11'd1024, 64'd3);
    send_item(ACT_QUERY, 11'd1, 11'd1, '0);
    send_item(ACT_QUERY, 11'd1024, 11'd1024, '0);
    send_item(ACT_ADD, 11'd300, 11'd700, 64'h8000_0000_0000_0001);
    send_item(ACT_QUERY, 11'd299, 11'd701, '0);
    send_item(ACT_QUERY, 11'd1, 11'd1024, '0);
    send_item(ACT_ADD, 11'd0, 11'd10, 64'd1);
    send_item(ACT_QUERY, 11'd9, 11'd8, '0);
    send_item(ACT_QUERY, 11'd1, 11'd1025, '0);
    send_item(ACT_LOAD, 11'd0, 11'd0, 64'd7);
    send_item(ACT_LOAD, 11'd2047, 11'd2047, 64'd7);
    send_item(ACT_NONE, 11'd2047, 11'd2047, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_NONE, 11'd0, 11'd0, '0);
    drain();

    write_size(11'd0);
    send_item(ACT_LOAD, 11'd1, 11'd1, 64'd1);
    send_item(ACT_QUERY, 11'd1, 11'd1, '0);
    drain();

    write_size(11'd2047);
    send_item(ACT_QUERY, 11'd1, 11'd1024, '0);
    random_phase(250);
    drain();

    write_size(11'd5);
    random_phase(150);
    drain();

    write_size(11'd1365);
    random_phase(300);
    drain();

    write_size(11'd682);
    random_phase(300);
    drain();

    write_size(11'd1);
    random_phase(50);
    drain();

    write_size(11'd1024);
    random_phase(300);
    drain();

    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rast_pkg.sv
rtl/rast_ctrl.sv
rtl/rast_dp.sv
rtl/range_add_range_sum_tree.sv
rtl/rast_chk.sv
tb/tb_top.sv
